FILE: src/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants of the palindromic subsequence engine
// Holds the payload structs of both channels, the job descriptor that moves
// from the loader to the table engine, the buffer release and the engine's state type.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Default capacity in bytes of one stored string.
  localparam int LPS_MAX_LEN = 64;

  // Fixed field widths of the channels.
  localparam int LPS_CHAR_W  = 8;
  localparam int LPS_OUT_W   = 7;

  // Width of the length field of a job; covers the largest supported capacity.
  localparam int LPS_JOB_LEN_W = 13;

  typedef struct packed {
    logic [LPS_CHAR_W-1:0] char_in;
    logic                  is_last;
  } in_item_t;

  typedef struct packed {
    logic [LPS_OUT_W-1:0] lps_length;
    logic                 overflow;
  } out_item_t;

  // One complete string waiting for the table engine.
  typedef struct packed {
    logic                     bank;
    logic [LPS_JOB_LEN_W-1:0] len;
    logic                     ovf;
  } job_t;

  // The engine hands a string buffer back to the loader.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROW_RD,
    B_ROW_LATCH,
    B_CELL,
    B_DONE
  } back_state_t;

endpackage

FILE: src/longest_palindromic_subsequence_top.sv
// ----------------------------------------------------------------------------
// longest_palindromic_subsequence_top: palindromic subsequence length engine
// Loads a string byte by byte and reports the length of its longest
// palindromic subsequence, with a flag for bytes dropped beyond capacity.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | moves
//   --------+------------------------------+----------------------------------
//   input   | in_push, in_full, in_item    | one string byte and a last flag
//   result  | out_pop, out_empty, out_item | length and overflow, per string
//
// A byte transaction is taken in every cycle while in_full is low. A string of
// n stored bytes then occupies the table engine for its walk through the row
// RAM, one cell per cycle, with a row read and a row latch step before each row.
// Reset is synchronous; no memory needs clearing. in_full rises only when both
// string buffers still wait for the engine; a held result stalls the engine.
//
module longest_palindromic_subsequence_top import lps_pkg::*; #(
  parameter int MAX_LEN = LPS_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_item,
  output logic      out_empty
);

  localparam int AW = $clog2(MAX_LEN);

  logic                  job_push;
  job_t                  job_in;
  logic                  job_pop;
  logic                  job_empty;
  job_t                  job_head;
  rel_t                  rel;
  logic                  mem_we;
  logic [AW:0]           mem_waddr;
  logic [LPS_CHAR_W-1:0] mem_wdata;
  logic [AW:0]           char_raddr;
  logic [LPS_CHAR_W-1:0] char_rdata;
  logic                  out_valid;

  // The loader fills one buffer while the engine reads the other.
  lps_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .rel       (rel),
    .job_push  (job_push),
    .job       (job_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // Both string buffers share one RAM; the top address bit picks the buffer,
  // so each buffer spans a full power-of-two address range.
  lps_ram #(
    .W     (LPS_CHAR_W),
    .DEPTH (2 << AW)
  ) u_char_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  // Completed strings wait here until the engine is free.
  lps_fifo u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .empty    (job_empty),
    .head     (job_head)
  );

  lps_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_empty  (job_empty),
    .job_head   (job_head),
    .job_pop    (job_pop),
    .rel        (rel),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .out_pop    (out_pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  // The result register is the one-entry output queue.
  assign out_empty = ~out_valid;

endmodule

FILE: src/lps_ram.sv
// ----------------------------------------------------------------------------
// lps_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front: string loader
// Writes incoming bytes into one of two string buffers, counts them, notes
// dropped bytes and posts a job when the final byte arrives.
// ----------------------------------------------------------------------------
module lps_front import lps_pkg::*; #(
  parameter int MAX_LEN = LPS_MAX_LEN,
  localparam int AW     = $clog2(MAX_LEN),
  localparam int LW     = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  input  rel_t                  rel,
  output logic                  job_push,
  output job_t                  job,
  output logic                  mem_we,
  output logic [AW:0]           mem_waddr,
  output logic [LPS_CHAR_W-1:0] mem_wdata
);

  logic [1:0]    busy_r, busy_nxt;
  logic          wb_r, wb_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic          acc;
  logic          store;
  logic [LW-1:0] n_new;

  // A buffer that still holds a string for the engine cannot be reloaded.
  assign in_full   = busy_r[wb_r];
  assign acc       = in_push & ~in_full;
  assign store     = (len_r != LW'(MAX_LEN));
  assign n_new     = store ? len_r + LW'(1) : len_r;

  assign mem_we    = acc & store;
  assign mem_waddr = {wb_r, len_r[AW-1:0]};
  assign mem_wdata = in_item.char_in;

  assign job_push  = acc & in_item.is_last;
  assign job.bank  = wb_r;
  assign job.len   = LPS_JOB_LEN_W'(n_new);
  assign job.ovf   = ovf_r | ~store;

  always_comb begin
    busy_nxt = busy_r;
    wb_nxt   = wb_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      len_nxt = n_new;
      ovf_nxt = ovf_r | ~store;
      if (in_item.is_last) begin
        busy_nxt[wb_r] = 1'b1;
        wb_nxt         = ~wb_r;
        len_nxt        = '0;
        ovf_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      wb_r   <= 1'b0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      wb_r   <= wb_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

FILE: src/lps_fifo.sv
// ----------------------------------------------------------------------------
// lps_fifo: job queue
// Two-entry queue of string jobs between the loader and the table engine.
// ----------------------------------------------------------------------------
module lps_fifo import lps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign head    = q_r[rp_r];
  assign do_push = push & (cnt_r != 2'd2);
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  // There are only two string buffers, so the queue can never be overrun.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2))
    else $error("job queue pushed while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("job queue count out of range");
`endif

endmodule

FILE: src/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back: table engine
// Fills the longest-common-subsequence table of a string against its reverse
// one cell per cycle, keeping a single row in RAM, and holds the result.
// ----------------------------------------------------------------------------
module lps_back import lps_pkg::*; #(
  parameter int MAX_LEN = LPS_MAX_LEN,
  localparam int AW     = $clog2(MAX_LEN),
  localparam int LW     = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  job_t                  job_head,
  output logic                  job_pop,
  output rel_t                  rel,
  output logic [AW:0]           char_raddr,
  input  logic [LPS_CHAR_W-1:0] char_rdata,
  input  logic                  out_pop,
  output logic                  out_valid,
  output out_item_t             out_item
);

  back_state_t           state_r, state_nxt;
  logic                  bank_r, bank_nxt;
  logic [LW-1:0]         n_r, n_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [LW-1:0]         i_r, i_nxt;
  logic [LW-1:0]         j_r, j_nxt;
  logic [LPS_CHAR_W-1:0] row_ch_r, row_ch_nxt;
  logic [LW-1:0]         left_r, left_nxt;
  logic [LW-1:0]         diag_r, diag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [LW-1:0]         issue_j;
  logic [LW-1:0]         rev_idx;
  logic [LW-1:0]         row_idx;
  logic [LW-1:0]         dp_rdata;
  logic [LW-1:0]         above;
  logic [LW-1:0]         cell_val;
  logic                  dp_we;
  logic [LW-1:0]         dp_widx;
  logic [LW-1:0]         dp_ridx;

  // Column j compares against byte n-j of the string.
  assign issue_j  = (state_r == B_ROW_LATCH) ? LW'(1) : j_r + LW'(1);
  assign rev_idx  = n_r - issue_j;
  assign row_idx  = i_r - LW'(1);
  assign char_raddr = (state_r inside {B_CELL, B_ROW_LATCH}) ?
                      {bank_r, rev_idx[AW-1:0]} : {bank_r, row_idx[AW-1:0]};

  // Entry k of the row RAM holds table column k+1; column 0 is always zero.
  assign dp_ridx  = issue_j - LW'(1);
  assign dp_widx  = j_r - LW'(1);
  assign dp_we    = (state_r == B_CELL);

  // The first row sees an all-zero row above it, so the RAM needs no clearing.
  assign above    = (i_r == LW'(1)) ? '0 : dp_rdata;
  assign cell_val = (row_ch_r == char_rdata) ? diag_r + LW'(1) :
                    ((left_r > above) ? left_r : above);

  lps_ram #(
    .W     (LW),
    .DEPTH (MAX_LEN)
  ) u_row_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_widx[AW-1:0]),
    .wdata (cell_val),
    .raddr (dp_ridx[AW-1:0]),
    .rdata (dp_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    row_ch_nxt    = row_ch_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    out_valid_nxt = out_valid_r & ~out_pop;
    out_item_nxt  = out_item_r;
    job_pop       = 1'b0;
    rel           = '{valid: 1'b0, bank: bank_r};
    case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          bank_nxt  = job_head.bank;
          n_nxt     = LW'(job_head.len);
          ovf_nxt   = job_head.ovf;
          i_nxt     = LW'(1);
          state_nxt = B_ROW_RD;
        end
      end
      B_ROW_RD: begin
        state_nxt = B_ROW_LATCH;
      end
      B_ROW_LATCH: begin
        row_ch_nxt = char_rdata;
        left_nxt   = '0;
        diag_nxt   = '0;
        j_nxt      = LW'(1);
        state_nxt  = B_CELL;
      end
      B_CELL: begin
        left_nxt = cell_val;
        diag_nxt = above;
        if (j_r != n_r) begin
          j_nxt = j_r + LW'(1);
        end else if (i_r != n_r) begin
          i_nxt     = i_r + LW'(1);
          state_nxt = B_ROW_RD;
        end else begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.lps_length = LPS_OUT_W'(left_r);
          out_item_nxt.overflow   = ovf_r;
          rel.valid               = 1'b1;
          state_nxt               = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r     <= bank_nxt;
    n_r        <= n_nxt;
    ovf_r      <= ovf_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    row_ch_r   <= row_ch_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // A job always carries at least the final byte and never more than capacity.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> (n_r >= LW'(1) && n_r <= LW'(MAX_LEN)))
    else $error("string length out of range in table engine");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CELL) |-> (j_r >= LW'(1) && j_r <= n_r && i_r <= n_r))
    else $error("table cell index out of range");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> (left_r <= n_r))
    else $error("subsequence longer than its string");
`endif

endmodule
